[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL; each use stands on a line of its own.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk_s, rst_s, cond) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) \
    else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/kptq_pkg.sv]
// ----------------------------------------------------------------------------
// kptq_pkg
// Types and codes of the keyed priority task queue.
// ----------------------------------------------------------------------------
package kptq_pkg;

  // Operation codes carried in the mode field
  typedef enum logic [1:0] {
    OP_ENQUEUE  = 2'd0,
    OP_SET_PRIO = 2'd1,
    OP_CANCEL   = 2'd2,
    OP_DISPATCH = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STS_DONE = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SCAN    = 4'b0010,
    S_REWRITE = 4'b0100,
    S_FINISH  = 4'b1000
  } state_t;

  // One table entry as held in the slot RAM
  typedef struct packed {
    logic        [15:0] key;
    logic signed [15:0] rank;
    logic        [31:0] handle;
  } entry_t;

  localparam int unsigned IN_W  = 72;
  localparam int unsigned OUT_W = 80;

endpackage

[hw/rtl/keyed_priority_task_queue.sv]
// ----------------------------------------------------------------------------
// keyed_priority_task_queue
// Insertion-ordered task table with keyed update, cancel and highest-rank
// dispatch, walked one entry per cycle through a slot RAM.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command word (mode, task_id, priority_req, payload);
//   m_* returns exactly one result word per command. cfg_wr_en/cfg_wr_data
//   set the signed urgent threshold; the user writes it only while the block
//   is idle, which the block itself does not enforce. Each command scans
//   the table through the single RAM read port for the first key match and
//   the highest rank; most then walk it again in a rewrite pass that
//   compacts out removed entries, applies updates and rebuilds the urgent
//   flag. A set-priority miss and a dispatch on an empty table skip the
//   rewrite pass. The next command is taken only after the result of the
//   last one is issued, so commands never overlap. The result sits in an
//   output register: a stalled receiver holds the next result back, while
//   one more command may still be accepted.
//   Reset empties the table (fill count to zero, no clearing pass), clears
//   the urgent flag and sets the threshold to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_priority_task_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  // fields from bit 0: mode[2], task_id[16], priority_req[16], payload[32]
  input  logic [kptq_pkg::IN_W-1:0]  s_tdata,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // fields from bit 0: dispatch_valid[1], dispatch_id[16],
  // dispatch_priority[16], dispatch_payload[32], status[2],
  // pending_count[5], urgent[1]
  output logic [kptq_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic                      cfg_wr_en,
  input  logic [15:0]               cfg_wr_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(kptq_pkg::entry_t);

  kptq_pkg::state_t  state;
  kptq_pkg::op_t     op;
  kptq_pkg::status_t status_r;
  kptq_pkg::status_t end_status;
  kptq_pkg::entry_t  rd_entry;
  kptq_pkg::entry_t  keep_entry;
  kptq_pkg::entry_t  best_entry;
  kptq_pkg::entry_t  req_entry;
  kptq_pkg::entry_t  ram_wdata;

  logic        [15:0] req_id;
  logic signed [15:0] req_rank;
  logic        [31:0] req_payload;
  logic signed [15:0] threshold;

  logic [CW-1:0] count;
  logic [CW-1:0] rd_ptr;
  logic [CW-1:0] wr_ptr;
  logic [CW-1:0] end_count;
  logic [AW-1:0] data_ptr;
  logic [AW-1:0] match_idx;
  logic [AW-1:0] best_idx;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_rdata;

  logic pend_q;
  logic found;
  logic urgent_r;
  logic urg_acc;
  logic rd_en;
  logic pass_done;
  logic key_hit;
  logic drop;
  logic append;
  logic end_urgent;
  logic ram_we;
  logic out_free;
  logic dv;

  // slot RAM
  kptq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (rd_en),
    .raddr(rd_ptr[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_entry  = kptq_pkg::entry_t'(ram_rdata);
  assign req_entry = '{key: req_id, rank: req_rank, handle: req_payload};

  // pass control: one read issued per cycle until the fill count is reached
  assign rd_en     = (state == kptq_pkg::S_SCAN || state == kptq_pkg::S_REWRITE) &&
                     (rd_ptr != count);
  assign pass_done = (rd_ptr == count) && !pend_q;
  assign key_hit   = rd_entry.key == req_id;
  assign s_tready  = state == kptq_pkg::S_IDLE;
  assign out_free  = !m_tvalid || m_tready;
  assign append    = (op == kptq_pkg::OP_ENQUEUE) && !found &&
                     (count < CW'(QUEUE_DEPTH));

  // entry as kept by the rewrite pass, and whether it leaves the table
  always_comb begin
    keep_entry = rd_entry;
    if (found && data_ptr == match_idx) begin
      if (op == kptq_pkg::OP_ENQUEUE) begin
        keep_entry = req_entry;
      end else if (op == kptq_pkg::OP_SET_PRIO) begin
        keep_entry.rank = req_rank;
      end
    end
    drop = ((op == kptq_pkg::OP_CANCEL) && key_hit) ||
           ((op == kptq_pkg::OP_DISPATCH) && data_ptr == best_idx);
  end

  // RAM write: compacted entries during rewrite, appended entry at its end
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_ptr[AW-1:0];
    ram_wdata = keep_entry;
    if (state == kptq_pkg::S_REWRITE) begin
      if (pend_q && !drop) begin
        ram_we = 1'b1;
      end else if (pass_done && append) begin
        ram_we    = 1'b1;
        ram_waddr = count[AW-1:0];
        ram_wdata = req_entry;
      end
    end
  end

  // outcome at the end of the rewrite pass
  always_comb begin
    end_urgent = urg_acc || (append && req_rank >= threshold);
    unique case (op)
      kptq_pkg::OP_ENQUEUE: begin
        end_count  = append ? CW'(count + 1'b1) : count;
        end_status = (!found && !append) ? kptq_pkg::STS_FULL : kptq_pkg::STS_DONE;
      end
      kptq_pkg::OP_SET_PRIO: begin
        end_count  = count;
        end_status = kptq_pkg::STS_DONE;
      end
      kptq_pkg::OP_CANCEL: begin
        end_count  = wr_ptr;
        end_status = found ? kptq_pkg::STS_DONE : kptq_pkg::STS_MISS;
      end
      kptq_pkg::OP_DISPATCH: begin
        end_count  = wr_ptr;
        end_status = kptq_pkg::STS_DONE;
      end
    endcase
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kptq_pkg::S_IDLE;
      count    <= '0;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      pend_q   <= 1'b0;
      found    <= 1'b0;
      urgent_r <= 1'b0;
      urg_acc  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      pend_q <= rd_en;
      if (rd_en) begin
        rd_ptr <= CW'(rd_ptr + 1'b1);
      end
      unique case (state)
        kptq_pkg::S_IDLE: begin
          if (s_tvalid) begin
            rd_ptr <= '0;
            found  <= 1'b0;
            state  <= kptq_pkg::S_SCAN;
          end
        end
        kptq_pkg::S_SCAN: begin
          if (pend_q && key_hit) begin
            found <= 1'b1;
          end
          if (pass_done) begin
            rd_ptr  <= '0;
            wr_ptr  <= '0;
            urg_acc <= 1'b0;
            if ((op == kptq_pkg::OP_SET_PRIO && !found) ||
                (op == kptq_pkg::OP_DISPATCH && count == '0)) begin
              state <= kptq_pkg::S_FINISH;
            end else begin
              state <= kptq_pkg::S_REWRITE;
            end
          end
        end
        kptq_pkg::S_REWRITE: begin
          if (pend_q && !drop) begin
            wr_ptr <= CW'(wr_ptr + 1'b1);
            if (keep_entry.rank >= threshold) begin
              urg_acc <= 1'b1;
            end
          end
          if (pass_done) begin
            count    <= end_count;
            urgent_r <= end_urgent;
            state    <= kptq_pkg::S_FINISH;
          end
        end
        kptq_pkg::S_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= kptq_pkg::S_IDLE;
          end
        end
        default: begin
          state <= kptq_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign dv = (op == kptq_pkg::OP_DISPATCH) && (status_r == kptq_pkg::STS_DONE);

  // datapath registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_ptr <= rd_ptr[AW-1:0];
    end
    unique case (state)
      kptq_pkg::S_IDLE: begin
        if (s_tvalid) begin
          op          <= kptq_pkg::op_t'(s_tdata[1:0]);
          req_id      <= s_tdata[17:2];
          req_rank    <= s_tdata[33:18];
          req_payload <= s_tdata[65:34];
        end
      end
      kptq_pkg::S_SCAN: begin
        // first key match and earliest highest rank
        if (pend_q && key_hit && !found) begin
          match_idx <= data_ptr;
        end
        if (pend_q && (data_ptr == '0 || rd_entry.rank > best_entry.rank)) begin
          best_entry <= rd_entry;
          best_idx   <= data_ptr;
        end
        if (pass_done) begin
          status_r <= kptq_pkg::STS_MISS;
        end
      end
      kptq_pkg::S_REWRITE: begin
        if (pass_done) begin
          status_r <= end_status;
        end
      end
      kptq_pkg::S_FINISH: begin
        if (out_free) begin
          m_tdata <= {7'b0, urgent_r, 5'(count), status_r,
                      dv ? best_entry.handle : 32'b0,
                      dv ? best_entry.rank   : 16'sb0,
                      dv ? best_entry.key    : 16'b0,
                      dv};
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(QUEUE_DEPTH))
  `ASSERT_IMPLIES(a_wr_behind_rd, clk, rst, state == kptq_pkg::S_REWRITE, wr_ptr <= rd_ptr)
  `ASSERT_IMPLIES(a_disp_ok, clk, rst, m_tvalid & m_tdata[0], m_tdata[66:65] == kptq_pkg::STS_DONE)
  `ASSERT_NEXT(a_count_hold, clk, rst, state != kptq_pkg::S_REWRITE, $stable(count))

endmodule

[hw/rtl/kptq_ram.sv]
// ----------------------------------------------------------------------------
// kptq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kptq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed priority task queue. Command words go in
// on the s_ stream; each one is predicted against a shadow task table and the
// expected result word is queued. The m_ stream is drained with random back
// pressure and every result is compared field by field in arrival order.
// Directed cases cover empty, full, tie and miss behaviour, then threshold
// extremes, then random phases with a fresh threshold for each phase.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH      = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES     = 16;
  localparam int PHASE_LEN  = 100;

  // Expected content of one result word
  typedef struct {
    logic               valid;
    logic        [15:0] id;
    logic signed [15:0] prio;
    logic        [31:0] payload;
    kptq_pkg::status_t  status;
    logic        [4:0]  count;
    logic               urgent;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [71:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  // Shadow task table
  logic        [15:0] tbl_key    [DEPTH];
  logic signed [15:0] tbl_rank   [DEPTH];
  logic        [31:0] tbl_handle [DEPTH];
  int                 tbl_len = 0;
  logic               tbl_urgent = 1'b0;
  logic signed [15:0] urgent_thr = '0;

  result_t pending_results[$];
  int      fail_count = 0;
  bit      steady = 1'b0;   // no idling on either side while set
  int      idle_cycles = 0;

  keyed_priority_task_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tdata    (m_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow table helpers
  // --------------------------------------------------------------------------
  function automatic void refresh_urgent();
    tbl_urgent = 1'b0;
    for (int i = 0; i < tbl_len; i++) begin
      if (tbl_rank[i] >= urgent_thr) tbl_urgent = 1'b1;
    end
  endfunction

  // close the gap left by the entry at pos
  function automatic void remove_slot(int pos);
    for (int i = pos; i + 1 < tbl_len; i++) begin
      tbl_key[i]    = tbl_key[i + 1];
      tbl_rank[i]   = tbl_rank[i + 1];
      tbl_handle[i] = tbl_handle[i + 1];
    end
    tbl_len--;
  endfunction

  // Apply one command to the shadow table and return the result word it gives
  function automatic result_t apply_command(kptq_pkg::op_t op, logic [15:0] id,
                                            logic signed [15:0] prio,
                                            logic [31:0] pl);
    result_t r;
    int      hit;
    int      best;
    int      i;
    r.valid   = 1'b0;
    r.id      = '0;
    r.prio    = '0;
    r.payload = '0;
    r.status  = kptq_pkg::STS_DONE;
    hit = -1;
    for (i = 0; i < tbl_len; i++) begin
      if (tbl_key[i] == id && hit < 0) hit = i;
    end
    case (op)
      kptq_pkg::OP_ENQUEUE: begin
        if (hit >= 0) begin
          tbl_rank[hit]   = prio;
          tbl_handle[hit] = pl;
        end else if (tbl_len < DEPTH) begin
          tbl_key[tbl_len]    = id;
          tbl_rank[tbl_len]   = prio;
          tbl_handle[tbl_len] = pl;
          tbl_len++;
        end else begin
          r.status = kptq_pkg::STS_FULL;
        end
        refresh_urgent();
      end
      kptq_pkg::OP_SET_PRIO: begin
        if (hit >= 0) begin
          tbl_rank[hit] = prio;
          refresh_urgent();
        end else begin
          r.status = kptq_pkg::STS_MISS;
        end
      end
      kptq_pkg::OP_CANCEL: begin
        if (hit < 0) r.status = kptq_pkg::STS_MISS;
        i = 0;
        while (i < tbl_len) begin
          if (tbl_key[i] == id) remove_slot(i);
          else i++;
        end
        refresh_urgent();
      end
      default: begin
        if (tbl_len == 0) begin
          r.status = kptq_pkg::STS_MISS;
        end else begin
          // strict compare keeps the earliest entry on a tie
          best = 0;
          for (i = 1; i < tbl_len; i++) begin
            if (tbl_rank[i] > tbl_rank[best]) best = i;
          end
          r.valid   = 1'b1;
          r.id      = tbl_key[best];
          r.prio    = tbl_rank[best];
          r.payload = tbl_handle[best];
          remove_slot(best);
          refresh_urgent();
        end
      end
    endcase
    r.count  = 5'(tbl_len);
    r.urgent = tbl_urgent;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driving and checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    fail_count++;
    $display("[%0t] mismatch %0d: %s", $time, fail_count, msg);
  endtask

  // send one command word, predicting its result on acceptance
  task automatic send_word(kptq_pkg::op_t op, logic [15:0] id,
                           logic signed [15:0] prio, logic [31:0] pl);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {6'd0, pl, prio, id, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_command(op, id, prio, pl));
  endtask

  // sender holds off until every result is back and the block is idle
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(logic signed [15:0] thr);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= thr;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    urgent_thr = thr;
  endtask

  // Receiver: random stalls, compare each word with the oldest expectation
  initial begin
    int      gap;
    result_t want;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[0] !== want.valid)
          report_mismatch($sformatf("dispatch_valid %b, want %b", m_tdata[0], want.valid));
        if (m_tdata[16:1] !== want.id)
          report_mismatch($sformatf("dispatch_id %h, want %h", m_tdata[16:1], want.id));
        if (m_tdata[32:17] !== want.prio)
          report_mismatch($sformatf("dispatch_priority %h, want %h",
                                    m_tdata[32:17], want.prio));
        if (m_tdata[64:33] !== want.payload)
          report_mismatch($sformatf("dispatch_payload %h, want %h",
                                    m_tdata[64:33], want.payload));
        if (m_tdata[66:65] !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", m_tdata[66:65], want.status));
        if (m_tdata[71:67] !== want.count)
          report_mismatch($sformatf("pending_count %0d, want %0d",
                                    m_tdata[71:67], want.count));
        if (m_tdata[72] !== want.urgent)
          report_mismatch($sformatf("urgent %b, want %b", m_tdata[72], want.urgent));
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // empty table, extremes, in-place update, tie, misses, full table
  task automatic test_directed();
    send_word(kptq_pkg::OP_DISPATCH, 16'h0000, 16'sd0, 32'h0);
    send_word(kptq_pkg::OP_SET_PRIO, 16'h1234, 16'sd9, 32'h0);
    send_word(kptq_pkg::OP_CANCEL,   16'h1234, 16'sd0, 32'h0);
    send_word(kptq_pkg::OP_ENQUEUE,  16'h0000, -16'sd32768, 32'h0000_0000);
    send_word(kptq_pkg::OP_ENQUEUE,  16'hFFFF, 16'sd32767, 32'hFFFF_FFFF);
    send_word(kptq_pkg::OP_ENQUEUE,  16'h0000, 16'sd5, 32'hA5A5_5A5A);
    send_word(kptq_pkg::OP_ENQUEUE,  16'h0002, 16'sd5, 32'h5A5A_A5A5);
    send_word(kptq_pkg::OP_SET_PRIO, 16'hFFFF, -16'sd1, 32'h0);
    send_word(kptq_pkg::OP_SET_PRIO, 16'h1234, 16'sd7, 32'h0);
    // tie between keys 0 and 2: the earlier one leaves
    send_word(kptq_pkg::OP_DISPATCH, 16'h0000, 16'sd0, 32'h0);
    for (int i = 0; i < DEPTH - 2; i++) begin
      send_word(kptq_pkg::OP_ENQUEUE, 16'(16'h0100 + i), 16'(i * 1000 - 7000), $urandom);
    end
    send_word(kptq_pkg::OP_ENQUEUE, 16'h7FFF, 16'sd100, 32'hDEAD_BEEF);
    send_word(kptq_pkg::OP_ENQUEUE, 16'h0002, 16'sd200, 32'h1234_5678);
    wait_results_drained();
  endtask

  // urgent flag under threshold extremes; a write alone leaves the flag
  task automatic test_threshold();
    logic signed [15:0] thr_list[5];
    thr_list = '{16'sd32767, -16'sd32768, -16'sd1, 16'sd0, 16'($urandom)};
    foreach (thr_list[k]) begin
      write_threshold(thr_list[k]);
      send_word(kptq_pkg::OP_SET_PRIO, 16'h7777, 16'sd0, 32'h0);
      if (k == 0) begin
        while (tbl_len > 0) send_word(kptq_pkg::OP_DISPATCH, 16'h0, 16'sd0, 32'h0);
      end
      send_word(kptq_pkg::OP_ENQUEUE,  16'h0040, thr_list[k], $urandom);
      send_word(kptq_pkg::OP_ENQUEUE,  16'h0041, thr_list[k] - 16'sd1, $urandom);
      send_word(kptq_pkg::OP_DISPATCH, 16'h0000, 16'sd0, 32'h0);
      send_word(kptq_pkg::OP_SET_PRIO, 16'h0041, thr_list[k], 32'h0);
      send_word(kptq_pkg::OP_CANCEL,   16'h0041, 16'sd0, 32'h0);
      wait_results_drained();
    end
  endtask

  // random phases: fill, balanced and drain biased mixes
  task automatic test_random();
    int                 r;
    kptq_pkg::op_t      op;
    logic        [15:0] id;
    logic signed [15:0] prio;
    for (int ph = 0; ph < PHASES; ph++) begin
      steady = (ph % 4 == 3);
      if (ph == 0)      write_threshold(-16'sd32768);
      else if (ph == 1) write_threshold(16'sd32767);
      else              write_threshold(16'($urandom));
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(0, 99);
        case (ph % 3)
          0:       op = r < 55 ? kptq_pkg::OP_ENQUEUE : r < 70 ? kptq_pkg::OP_SET_PRIO :
                        r < 80 ? kptq_pkg::OP_CANCEL : kptq_pkg::OP_DISPATCH;
          1:       op = r < 35 ? kptq_pkg::OP_ENQUEUE : r < 55 ? kptq_pkg::OP_SET_PRIO :
                        r < 70 ? kptq_pkg::OP_CANCEL : kptq_pkg::OP_DISPATCH;
          default: op = r < 20 ? kptq_pkg::OP_ENQUEUE : r < 35 ? kptq_pkg::OP_SET_PRIO :
                        r < 55 ? kptq_pkg::OP_CANCEL : kptq_pkg::OP_DISPATCH;
        endcase
        // keys: mostly a small pool or a pending one, now and then anything
        r = $urandom_range(0, 9);
        if (r == 0)                     id = 16'($urandom);
        else if (r < 5 && tbl_len > 0)  id = tbl_key[$urandom_range(0, tbl_len - 1)];
        else                            id = 16'($urandom_range(0, 19));
        r = $urandom_range(0, 9);
        if (r == 0)     prio = ($urandom_range(0, 1) != 0) ? 16'sd32767 : -16'sd32768;
        else if (r < 4) prio = urgent_thr + 16'($urandom_range(0, 4)) - 16'sd2;
        else            prio = 16'($urandom);
        send_word(op, id, prio, $urandom);
      end
      wait_results_drained();
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_threshold();
    test_random();
    wait_results_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
